### hw/rtl/smm_pkg.sv
// Shared widths, defaults and the control bundle of the systolic matrix multiply.
package smm_pkg;

   // Default matrix dimension.
   localparam int DIM_DEFAULT = 4;

   // Fixed field widths of the request and response items.
   localparam int FIELD_W = 2;
   localparam int A_W     = 16;
   localparam int PROD_W  = 2 * A_W;
   localparam int ACC_W   = 40;

   // Packed stream widths, padded to whole bytes.
   localparam int REQ_DATA_W = 40;
   localparam int RSP_DATA_W = 48;

   // Control bundle that the sequencer drives into every cell.
   typedef struct packed {
      logic clear;     // zero the held operands and accumulators
      logic step_en;   // take operands from the neighbors, form the product
      logic acc_en;    // add the registered product into the accumulator
      logic shift_en;  // move accumulators one place down the unload chain
   } ctrl_type;

endpackage

### hw/rtl/smm_feed.sv
// Edge feeder for one lane: holds row ID of A and column ID of B and injects them with skew.
module smm_feed import smm_pkg::*; #(
   parameter int DIM = DIM_DEFAULT,
   parameter int ID  = 0
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_accept,
   input  logic [FIELD_W-1:0]                   lane,
   input  logic [FIELD_W-1:0]                   step_index,
   input  logic signed [A_W-1:0]                a_value,
   input  logic signed [A_W-1:0]                b_value,
   input  logic                                 issue_valid,
   input  logic [$clog2(3 * DIM - 2)-1:0]       issue_step,
   output logic signed [A_W-1:0]                a_edge,
   output logic signed [A_W-1:0]                b_edge
);

   localparam int IDX_W  = $clog2(DIM);
   localparam int STEP_W = $clog2(3 * DIM - 2);

   // A[ID][k] and B[k][ID], both addressed by the inner-product index k.
   logic signed [A_W-1:0] a_mem [DIM];
   logic signed [A_W-1:0] b_mem [DIM];

   logic                  write_en;
   logic [IDX_W-1:0]      write_addr;
   logic                  read_hit;
   logic [IDX_W-1:0]      read_addr;
   logic signed [A_W-1:0] a_rd_ff;
   logic signed [A_W-1:0] b_rd_ff;
   logic                  hit_ff;
   logic                  hit_in;

   assign write_en   = req_accept && (32'(lane) == ID) && (32'(step_index) < DIM);
   assign write_addr = IDX_W'(step_index);

   // Lane ID sees element k = t - ID at step t, zero outside the matrix.
   assign read_hit  = (issue_step >= STEP_W'(ID)) && (issue_step < STEP_W'(ID + DIM));
   assign read_addr = IDX_W'(issue_step - STEP_W'(ID));
   assign hit_in    = issue_valid && read_hit;

   always_ff @(posedge clock) begin
      if (write_en) begin
         a_mem[write_addr] <= a_value;
         b_mem[write_addr] <= b_value;
      end
      a_rd_ff <= a_mem[read_addr];
      b_rd_ff <= b_mem[read_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hit_ff <= 1'b0;
      end else begin
         hit_ff <= hit_in;
      end
   end

   assign a_edge = hit_ff ? a_rd_ff : '0;
   assign b_edge = hit_ff ? b_rd_ff : '0;

endmodule

### hw/rtl/smm_cell.sv
// One multiply-accumulate cell of the output-stationary grid.
module smm_cell import smm_pkg::*; (
   input  logic                    clock,
   input  logic                    reset,
   input  ctrl_type                ctrl,
   input  logic signed [A_W-1:0]   a_in,
   input  logic signed [A_W-1:0]   b_in,
   input  logic signed [ACC_W-1:0] acc_shift_in,
   output logic signed [A_W-1:0]   a_out,
   output logic signed [A_W-1:0]   b_out,
   output logic signed [ACC_W-1:0] acc_out
);

   logic signed [A_W-1:0]    a_ff;
   logic signed [A_W-1:0]    b_ff;
   logic signed [PROD_W-1:0] prod_ff;
   logic signed [PROD_W-1:0] prod_in;
   logic signed [ACC_W-1:0]  acc_ff;
   logic signed [ACC_W-1:0]  acc_in;

   assign prod_in = PROD_W'(a_in) * PROD_W'(b_in);

   always_comb begin
      acc_in = acc_ff;
      if (ctrl.clear) begin
         acc_in = '0;
      end else if (ctrl.acc_en) begin
         acc_in = acc_ff + ACC_W'(prod_ff);
      end else if (ctrl.shift_en) begin
         acc_in = acc_shift_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_ff   <= '0;
         b_ff   <= '0;
         acc_ff <= '0;
      end else begin
         if (ctrl.clear) begin
            a_ff <= '0;
            b_ff <= '0;
         end else if (ctrl.step_en) begin
            a_ff <= a_in;
            b_ff <= b_in;
         end
         acc_ff <= acc_in;
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.step_en) begin
         prod_ff <= prod_in;
      end
   end

   assign a_out   = a_ff;
   assign b_out   = b_ff;
   assign acc_out = acc_ff;

endmodule

### hw/rtl/smm_ctrl.sv
// Sequencer: load, compute steps, pipeline drain and row-major result unload.
module smm_ctrl import smm_pkg::*; #(
   parameter int DIM = DIM_DEFAULT
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_accept,
   input  logic                             req_last,
   output logic                             req_ready,
   output ctrl_type                         ctrl,
   output logic                             issue_valid,
   output logic [$clog2(3 * DIM - 2)-1:0]   issue_step,
   input  logic signed [ACC_W-1:0]          acc_head,
   input  logic                             rsp_ready,
   output logic                             rsp_valid,
   output logic [FIELD_W-1:0]               rsp_row,
   output logic [FIELD_W-1:0]               rsp_col,
   output logic signed [ACC_W-1:0]          rsp_value,
   output logic                             rsp_last
);

   localparam int IDX_W  = $clog2(DIM);
   localparam int STEPS  = 3 * DIM - 2;
   localparam int STEP_W = $clog2(STEPS);

   localparam logic [1:0] ST_LOAD  = 2'd0;
   localparam logic [1:0] ST_RUN   = 2'd1;
   localparam logic [1:0] ST_DRAIN = 2'd2;
   localparam logic [1:0] ST_EMIT  = 2'd3;

   logic [1:0]              state_ff, state_in;
   logic [STEP_W-1:0]       step_ff, step_in;
   logic                    s1_ff, s2_ff;
   logic [IDX_W-1:0]        row_ff, row_in;
   logic [IDX_W-1:0]        col_ff, col_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   logic [FIELD_W-1:0]      rsp_row_ff, rsp_col_ff;
   logic signed [ACC_W-1:0] rsp_value_ff;
   logic                    rsp_last_ff;
   logic                    start;
   logic                    unload;
   logic                    final_elem;

   assign start       = req_accept && req_last;
   assign issue_valid = (state_ff == ST_RUN);
   assign issue_step  = step_ff;
   assign final_elem  = (row_ff == IDX_W'(DIM - 1)) && (col_ff == IDX_W'(DIM - 1));
   assign unload      = (state_ff == ST_EMIT) && (!rsp_valid_ff || rsp_ready);

   always_comb begin
      state_in     = state_ff;
      step_in      = step_ff;
      row_in       = row_ff;
      col_in       = col_ff;
      rsp_valid_in = rsp_valid_ff;
      if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
      case (state_ff)
         ST_LOAD: begin
            if (start) begin
               state_in = ST_RUN;
               step_in  = '0;
            end
         end
         ST_RUN: begin
            step_in = step_ff + 1'b1;
            if (step_ff == STEP_W'(STEPS - 1)) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            if (!s1_ff && !s2_ff) begin
               state_in = ST_EMIT;
               row_in   = '0;
               col_in   = '0;
            end
         end
         ST_EMIT: begin
            if (unload) begin
               rsp_valid_in = 1'b1;
               if (col_ff == IDX_W'(DIM - 1)) begin
                  col_in = '0;
                  row_in = row_ff + 1'b1;
               end else begin
                  col_in = col_ff + 1'b1;
               end
               if (final_elem) begin
                  state_in = ST_LOAD;
               end
            end
         end
         default: begin
            state_in = ST_LOAD;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_LOAD;
         step_ff      <= '0;
         s1_ff        <= 1'b0;
         s2_ff        <= 1'b0;
         row_ff       <= '0;
         col_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         step_ff      <= step_in;
         s1_ff        <= issue_valid;
         s2_ff        <= s1_ff;
         row_ff       <= row_in;
         col_ff       <= col_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (unload) begin
         rsp_row_ff   <= FIELD_W'(row_ff);
         rsp_col_ff   <= FIELD_W'(col_ff);
         rsp_value_ff <= acc_head;
         rsp_last_ff  <= final_elem;
      end
   end

   always_comb begin
      ctrl          = '0;
      ctrl.clear    = start;
      ctrl.step_en  = s1_ff;
      ctrl.acc_en   = s2_ff;
      ctrl.shift_en = unload;
   end

   assign req_ready = (state_ff == ST_LOAD);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_row   = rsp_row_ff;
   assign rsp_col   = rsp_col_ff;
   assign rsp_value = rsp_value_ff;
   assign rsp_last  = rsp_last_ff;

endmodule

### hw/rtl/systolic_matrix_multiply.sv
// Top level of the output-stationary systolic matrix multiply, C = A x B.
//
// Usage. Each request on the req_ channel carries one pair: A[lane][step_index]
// and B[step_index][lane], both signed Q8.8. The pair is written into the
// operand stores of lane "lane". A request with req_tlast high is stored and
// then starts the multiply; stores keep their contents between matrices, so a
// new load may rewrite only some elements. Pairs with an index of DIM or more
// are dropped, but their tlast still starts the multiply.
// The compute runs 3*DIM-2 steps through a DIM x DIM grid of cells: A moves
// right, B moves down, each cell accumulates in 40 bits (Q24.16). The lane
// feeders add the row and column skew at the grid edges.
// Results leave on the rsp_ channel as DIM*DIM requests in row-major order,
// the last one marked with rsp_tlast. Timing: one load request per cycle
// while loading; after the tlast request the compute steps and then the
// read, multiply and accumulate stages pass before the first result, then
// one result per cycle while rsp_tready is high. req_tready is high only
// while loading. A stalled receiver holds the result in the output
// register and freezes the unload chain. Synchronous reset clears control,
// cell holds and accumulators; the stores stay as is.
module systolic_matrix_multiply import smm_pkg::*; #(
   parameter int DIM = DIM_DEFAULT
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   // lane [1:0], step_index [3:2], a_value [19:4], b_value [35:20], zero [39:36]
   input  logic [REQ_DATA_W-1:0] req_tdata,
   input  logic                  req_tlast,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   // row [1:0], col [3:2], result_value [43:4], zero [47:44]
   output logic [RSP_DATA_W-1:0] rsp_tdata,
   output logic                  rsp_tlast
);

   localparam int CELLS  = DIM * DIM;
   localparam int STEP_W = $clog2(3 * DIM - 2);

   logic                    req_accept;
   logic [FIELD_W-1:0]      lane;
   logic [FIELD_W-1:0]      step_index;
   logic signed [A_W-1:0]   a_value;
   logic signed [A_W-1:0]   b_value;
   ctrl_type                ctrl;
   logic                    issue_valid;
   logic [STEP_W-1:0]       issue_step;
   logic [FIELD_W-1:0]      rsp_row;
   logic [FIELD_W-1:0]      rsp_col;
   logic signed [ACC_W-1:0] rsp_value;

   logic signed [A_W-1:0]   feed_a  [DIM];
   logic signed [A_W-1:0]   feed_b  [DIM];
   logic signed [A_W-1:0]   a_out   [CELLS];
   logic signed [A_W-1:0]   b_out   [CELLS];
   logic signed [ACC_W-1:0] acc_out [CELLS];

   assign req_accept = req_tvalid && req_tready;
   assign lane       = req_tdata[1:0];
   assign step_index = req_tdata[3:2];
   assign a_value    = req_tdata[19:4];
   assign b_value    = req_tdata[35:20];

   smm_ctrl #(.DIM(DIM)) u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_accept  (req_accept),
      .req_last    (req_tlast),
      .req_ready   (req_tready),
      .ctrl        (ctrl),
      .issue_valid (issue_valid),
      .issue_step  (issue_step),
      .acc_head    (acc_out[0]),
      .rsp_ready   (rsp_tready),
      .rsp_valid   (rsp_tvalid),
      .rsp_row     (rsp_row),
      .rsp_col     (rsp_col),
      .rsp_value   (rsp_value),
      .rsp_last    (rsp_tlast)
   );

   // One feeder per lane drives row "lane" at the left edge and column
   // "lane" at the top edge.
   for (genvar n = 0; n < DIM; n++) begin : g_feed
      smm_feed #(.DIM(DIM), .ID(n)) u_feed (
         .clock       (clock),
         .reset       (reset),
         .req_accept  (req_accept),
         .lane        (lane),
         .step_index  (step_index),
         .a_value     (a_value),
         .b_value     (b_value),
         .issue_valid (issue_valid),
         .issue_step  (issue_step),
         .a_edge      (feed_a[n]),
         .b_edge      (feed_b[n])
      );
   end

   // Grid of cells. Accumulators also form a row-major chain that drains
   // toward cell zero during the unload.
   for (genvar i = 0; i < DIM; i++) begin : g_row
      for (genvar j = 0; j < DIM; j++) begin : g_col
         localparam int K = i * DIM + j;
         logic signed [A_W-1:0]   a_in;
         logic signed [A_W-1:0]   b_in;
         logic signed [ACC_W-1:0] acc_next;

         if (j == 0) begin : g_a_edge
            assign a_in = feed_a[i];
         end else begin : g_a_link
            assign a_in = a_out[K-1];
         end

         if (i == 0) begin : g_b_edge
            assign b_in = feed_b[j];
         end else begin : g_b_link
            assign b_in = b_out[K-DIM];
         end

         if (K == CELLS - 1) begin : g_chain_end
            assign acc_next = '0;
         end else begin : g_chain_link
            assign acc_next = acc_out[K+1];
         end

         smm_cell u_cell (
            .clock        (clock),
            .reset        (reset),
            .ctrl         (ctrl),
            .a_in         (a_in),
            .b_in         (b_in),
            .acc_shift_in (acc_next),
            .a_out        (a_out[K]),
            .b_out        (b_out[K]),
            .acc_out      (acc_out[K])
         );
      end
   end

   assign rsp_tdata = {4'b0000, rsp_value, rsp_col, rsp_row};

endmodule

### hw/rtl/smm_checker.sv
// Port-level checks of the systolic matrix multiply, bound to its top level.
module smm_checker (
   input logic clock,
   input logic reset,
   input logic req_tvalid,
   input logic req_tready,
   input logic req_tlast,
   input logic rsp_tvalid,
   input logic rsp_tready,
   input logic rsp_tlast
);

   // A stalled result stays offered.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid)
      else $error("result dropped while stalled");

   // After reset the block is loading and shows no result.
   a_reset_state: assert property (@(posedge clock)
      reset |=> req_tready && !rsp_tvalid)
      else $error("wrong state after reset");

   // A final load request starts the compute, so loading stops.
   a_start: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready && req_tlast |=> !req_tready)
      else $error("load still open after final request");

   // Loading reopens only once the last result sits in the output register.
   a_load_vs_unload: assert property (@(posedge clock) disable iff (reset)
      req_tready && rsp_tvalid |-> rsp_tlast)
      else $error("load open during unload");

   // Nothing follows the final result of a matrix.
   a_last_ends: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tready && rsp_tlast |=> !rsp_tvalid)
      else $error("result after final result");

endmodule

bind systolic_matrix_multiply smm_checker u_smm_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .req_tlast  (req_tlast),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tlast  (rsp_tlast)
);

### dv/testbench.sv
// Self-checking testbench for the systolic matrix multiply: directed table, random loads, stalls.
`timescale 1ns / 100ps

module testbench;
   import smm_pkg::*;

   localparam int DIM          = DIM_DEFAULT;
   localparam int CELLS        = DIM * DIM;
   localparam int RANDOM_ITEMS = 157;
   localparam int HOLD_CYCLES  = 300;
   localparam int DRAIN_CYCLES = 4 * (3 * DIM + 2);
   localparam int CYCLE_LIMIT  = 200000;

   localparam logic signed [A_W-1:0]   OPND_MIN = 16'sh8000;
   localparam logic signed [A_W-1:0]   OPND_MAX = 16'sh7FFF;
   localparam logic signed [A_W-1:0]   OPND_ONE = 16'sh0100;
   // Four products of -128.0 * -128.0 give 65536.0 in Q24.16.
   localparam logic signed [ACC_W-1:0] CORNER_SUM = 40'sh01_0000_0000;

   typedef enum int {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_type;

   // One load request, plus an optional typed value that every result of the
   // matrix it starts must carry.
   typedef struct {
      logic [FIELD_W-1:0]      lane;
      logic [FIELD_W-1:0]      step_index;
      logic signed [A_W-1:0]   a_value;
      logic signed [A_W-1:0]   b_value;
      logic                    last_item;
      bit                      typed;
      logic signed [ACC_W-1:0] typed_value;
   } load_row_type;

   typedef struct {
      logic [FIELD_W-1:0]      row;
      logic [FIELD_W-1:0]      col;
      logic signed [ACC_W-1:0] value;
      logic                    last;
   } product_elem_type;

   logic                  clock      = 1'b0;
   logic                  reset      = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata  = '0;
   logic                  req_tlast  = 1'b0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic                  rsp_tlast;

   // Operand matrices as the block should hold them, and the products owed.
   logic signed [A_W-1:0] a_matrix [DIM][DIM];
   logic signed [A_W-1:0] b_matrix [DIM][DIM];
   product_elem_type      expected_products [$];

   idle_mode_type idle_mode    = IDLE_NONE;
   logic          hold_request = 1'b0;
   logic          rsp_hold     = 1'b0;
   int            mismatches   = 0;
   int            cycle_count  = 0;

   // The first sixteen rows write every element once, so no later matrix reads
   // an element that was never loaded.
   load_row_type directed_rows [23] = '{
      '{2'd0, 2'd0, OPND_MIN, OPND_MIN, 1'b0, 1'b0, 40'sd0},
      '{2'd0, 2'd1, OPND_MIN, OPND_MIN, 1'b0, 1'b0, 40'sd0},
      '{2'd0, 2'd2, OPND_MIN, OPND_MIN, 1'b0, 1'b0, 40'sd0},
      '{2'd0, 2'd3, OPND_MIN, OPND_MIN, 1'b0, 1'b0, 40'sd0},
      '{2'd1, 2'd0, OPND_MIN, OPND_MIN, 1'b0, 1'b0, 40'sd0},
      '{2'd1, 2'd1, OPND_MIN, OPND_MIN, 1'b0, 1'b0, 40'sd0},
      '{2'd1, 2'd2, OPND_MIN, OPND_MIN, 1'b0, 1'b0, 40'sd0},
      '{2'd1, 2'd3, OPND_MIN, OPND_MIN, 1'b0, 1'b0, 40'sd0},
      '{2'd2, 2'd0, OPND_MIN, OPND_MIN, 1'b0, 1'b0, 40'sd0},
      '{2'd2, 2'd1, OPND_MIN, OPND_MIN, 1'b0, 1'b0, 40'sd0},
      '{2'd2, 2'd2, OPND_MIN, OPND_MIN, 1'b0, 1'b0, 40'sd0},
      '{2'd2, 2'd3, OPND_MIN, OPND_MIN, 1'b0, 1'b0, 40'sd0},
      '{2'd3, 2'd0, OPND_MIN, OPND_MIN, 1'b0, 1'b0, 40'sd0},
      '{2'd3, 2'd1, OPND_MIN, OPND_MIN, 1'b0, 1'b0, 40'sd0},
      '{2'd3, 2'd2, OPND_MIN, OPND_MIN, 1'b0, 1'b0, 40'sd0},
      '{2'd3, 2'd3, OPND_MIN, OPND_MIN, 1'b1, 1'b1, CORNER_SUM},
      // Partial reload of lane 0 with the positive extreme.
      '{2'd0, 2'd0, OPND_MAX, OPND_MAX, 1'b0, 1'b0, 40'sd0},
      '{2'd0, 2'd1, OPND_MAX, OPND_MAX, 1'b0, 1'b0, 40'sd0},
      '{2'd0, 2'd2, OPND_MAX, OPND_MAX, 1'b0, 1'b0, 40'sd0},
      '{2'd0, 2'd3, OPND_MAX, OPND_MAX, 1'b1, 1'b0, 40'sd0},
      // A load of a single pair that also starts the multiply.
      '{2'd3, 2'd3, 16'sd0, 16'sd0, 1'b1, 1'b0, 40'sd0},
      '{2'd2, 2'd1, OPND_ONE, -16'sd1, 1'b0, 1'b0, 40'sd0},
      '{2'd1, 2'd2, -16'sd1, OPND_ONE, 1'b1, 1'b0, 40'sd0}
   };

   systolic_matrix_multiply #(.DIM(DIM)) u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   function automatic bit coin(input int percent);
      return $urandom_range(99) < percent;
   endfunction

   function automatic int sender_idle_pct();
      case (idle_mode)
         IDLE_SENDER: return 58;
         IDLE_BOTH:   return 36;
         default:     return 0;
      endcase
   endfunction

   function automatic int receiver_stall_pct();
      case (idle_mode)
         IDLE_RECEIVER: return 58;
         IDLE_BOTH:     return 36;
         default:       return 0;
      endcase
   endfunction

   // Extremes, zero and minus one show up often; the rest is uniform.
   function automatic logic signed [A_W-1:0] random_operand();
      case ($urandom_range(7))
         0:       return OPND_MIN;
         1:       return OPND_MAX;
         2:       return '0;
         3:       return '1;
         default: return A_W'($urandom);
      endcase
   endfunction

   // With the edge skew, cell (r, c) meets A[r][k] and B[k][c] at the same
   // step for every k, so each accumulator ends as the plain inner product.
   // The 40-bit sum of four Q16.16 products cannot overflow.
   function automatic void queue_products(input bit typed,
                                          input logic signed [ACC_W-1:0] typed_value);
      product_elem_type         elem;
      logic signed [ACC_W-1:0]  sum;
      logic signed [PROD_W-1:0] prod;
      for (int r = 0; r < DIM; r++) begin
         for (int c = 0; c < DIM; c++) begin
            sum = '0;
            for (int k = 0; k < DIM; k++) begin
               prod = a_matrix[r][k] * b_matrix[k][c];
               sum  = sum + prod;
            end
            elem.row   = FIELD_W'(r);
            elem.col   = FIELD_W'(c);
            elem.value = typed ? typed_value : sum;
            elem.last  = (r == DIM - 1) && (c == DIM - 1);
            expected_products.push_back(elem);
         end
      end
   endfunction

   task automatic report_mismatch(input string what);
      $display("MISMATCH at cycle %0d: %s", cycle_count, what);
      mismatches++;
   endtask

   // Offers one request after a random gap and returns at the edge that takes
   // it. The valid is left high; the next call either replaces the request or
   // lowers the valid, so the signal never sees two assignments in one step.
   task automatic send_request(input load_row_type row);
      while (coin(sender_idle_pct())) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {4'b0, row.b_value, row.a_value, row.step_index, row.lane};
      req_tlast  <= row.last_item;
      do @(posedge clock); while (!req_tready);
      // A request carries A[lane][step_index] and B[step_index][lane].
      a_matrix[row.lane][row.step_index] = row.a_value;
      b_matrix[row.step_index][row.lane] = row.b_value;
      if (row.last_item)
         queue_products(row.typed, row.typed_value);
   endtask

   // Lowers the valid in the current step and waits until every product owed
   // has been received.
   task automatic drain_products();
      req_tvalid <= 1'b0;
      while (expected_products.size() != 0)
         @(posedge clock);
   endtask

   task automatic check_product();
      product_elem_type got;
      product_elem_type want;
      got.row   = rsp_tdata[1:0];
      got.col   = rsp_tdata[3:2];
      got.value = rsp_tdata[43:4];
      got.last  = rsp_tlast;
      if (expected_products.size() == 0) begin
         report_mismatch($sformatf("unexpected result row %0d col %0d", got.row, got.col));
         return;
      end
      want = expected_products.pop_front();
      if (got.row !== want.row)
         report_mismatch($sformatf("row %0d, expected %0d", got.row, want.row));
      if (got.col !== want.col)
         report_mismatch($sformatf("col %0d, expected %0d", got.col, want.col));
      if (got.value !== want.value)
         report_mismatch($sformatf("C[%0d][%0d] = %0d, expected %0d",
                                   want.row, want.col, got.value, want.value));
      if (got.last !== want.last)
         report_mismatch($sformatf("tlast %b at C[%0d][%0d], expected %b",
                                   got.last, want.row, want.col, want.last));
   endtask

   // Receiver: checks each accepted result and picks the next ready value.
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready)
         check_product();
      rsp_tready <= rsp_hold ? 1'b0 : !coin(receiver_stall_pct());
   end

   // Long receiver hold-off. While it lasts the sender keeps offering, so the
   // unload chain freezes and the block stops taking requests.
   initial begin : hold_off
      int count;
      wait (hold_request);
      @(posedge clock);
      rsp_hold <= 1'b1;
      for (count = 0; count < HOLD_CYCLES; count++)
         @(posedge clock);
      rsp_hold <= 1'b0;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("testbench NOT OK");
         $finish;
      end
   end

   initial begin : stimulus
      load_row_type row;
      int           order [CELLS];
      int           items_sent;
      int           matrix_count;
      int           load_size;
      int           pick;
      int           swap;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (directed_rows[n])
         send_request(directed_rows[n]);

      // Random part: mostly short partial reloads, sometimes a full reload in
      // shuffled order. Idling changes every three matrices.
      items_sent   = 0;
      matrix_count = 0;
      while (items_sent < RANDOM_ITEMS) begin
         idle_mode = idle_mode_type'((matrix_count / 3) % 4);
         if (matrix_count == 2)
            hold_request = 1'b1;
         if (matrix_count == 9)
            drain_products();

         load_size = ($urandom_range(3) == 0) ? CELLS : $urandom_range(1, 6);
         for (int n = 0; n < CELLS; n++)
            order[n] = n;
         for (int n = CELLS - 1; n > 0; n--) begin
            pick        = $urandom_range(n);
            swap        = order[n];
            order[n]    = order[pick];
            order[pick] = swap;
         end
         for (int n = 0; n < load_size; n++) begin
            row.lane        = FIELD_W'(order[n] / DIM);
            row.step_index  = FIELD_W'(order[n] % DIM);
            row.a_value     = random_operand();
            row.b_value     = random_operand();
            row.last_item   = (n == load_size - 1);
            row.typed       = 1'b0;
            row.typed_value = '0;
            send_request(row);
            items_sent++;
         end
         matrix_count++;
      end

      drain_products();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatches == 0)
         $display("testbench OK");
      else
         $display("testbench NOT OK");
      $finish;
   end

endmodule

### files.f
hw/rtl/smm_pkg.sv
hw/rtl/smm_feed.sv
hw/rtl/smm_cell.sv
hw/rtl/smm_ctrl.sv
hw/rtl/systolic_matrix_multiply.sv
hw/rtl/smm_checker.sv
dv/testbench.sv
